// ----- design/bpenv_pkg.sv -----
// ---------------------------------------------------------------------------
// bpenv_pkg
// Shared constants, state type and controller/datapath interface structs
// for the breakpoint envelope lookup unit.
// ---------------------------------------------------------------------------
package bpenv_pkg;

  localparam int MAX_POINTS = 16;
  localparam int IDX_W      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int CFG_W      = 5;
  localparam int X_W        = 16;
  localparam int Y_W        = 16;
  localparam int FRAC_W     = 8;
  localparam int POS_W      = X_W + FRAC_W;
  localparam int PROD_W     = Y_W + POS_W;
  localparam int DIV_STEPS  = POS_W;
  localparam int DCNT_W     = $clog2(DIV_STEPS);
  localparam int ENTRY_W    = X_W + Y_W;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MUL,
    ST_DIV,
    ST_FIN,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    RES_ZERO,
    RES_DATA_Y,
    RES_INTERP
  } res_sel_t;

  typedef struct packed {
    logic     wr_entry;
    logic     start_query;
    logic     scan_step;
    logic     take_diff;
    logic     mul_load;
    logic     div_step;
    logic     load_res;
    res_sel_t res_sel;
  } cmd_t;

  typedef struct packed {
    logic passed;
    logic last;
    logic first;
    logic n_zero;
    logic n_gt1;
    logic div_last;
  } stat_t;

endpackage

// ----- design/bpenv_ram.sv -----
// ---------------------------------------------------------------------------
// bpenv_ram
// Generic memory, one write port and one read port, registered read data.
// ---------------------------------------------------------------------------
module bpenv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/bpenv_ctrl.sv -----
// ---------------------------------------------------------------------------
// bpenv_ctrl
// Sequencer for breakpoint writes and queries: scan, multiply, divide,
// result strobe.
// ---------------------------------------------------------------------------
module bpenv_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic            op,
  input  bpenv_pkg::stat_t stat,
  output bpenv_pkg::cmd_t  cmd,
  output logic            busy,
  output logic            out_valid
);
  import bpenv_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start && op == OP_QUERY) begin
          state_nxt = stat.n_zero ? ST_OUT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (stat.passed) begin
          if (stat.last) state_nxt = ST_OUT;
        end else if (stat.first) begin
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL:  state_nxt = ST_DIV;
      ST_DIV: begin
        if (stat.div_last) state_nxt = ST_FIN;
      end
      ST_FIN:  state_nxt = ST_OUT;
      ST_OUT:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd       = '0;
    cmd.res_sel = RES_ZERO;
    busy      = (state_r != ST_IDLE);
    out_valid = (state_r == ST_OUT);
    case (state_r)
      ST_IDLE: begin
        if (start && op == OP_WRITE) begin
          cmd.wr_entry = 1'b1;
        end else if (start && op == OP_QUERY) begin
          if (stat.n_zero) begin
            cmd.load_res = 1'b1;
            cmd.res_sel  = RES_ZERO;
          end else begin
            cmd.start_query = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        if (stat.passed) begin
          if (stat.last) begin
            // at or after the last breakpoint
            cmd.load_res = 1'b1;
            cmd.res_sel  = RES_DATA_Y;
          end else begin
            cmd.scan_step = 1'b1;
          end
        end else if (stat.first) begin
          // before the first breakpoint
          cmd.load_res = 1'b1;
          cmd.res_sel  = stat.n_gt1 ? RES_DATA_Y : RES_ZERO;
        end else begin
          cmd.take_diff = 1'b1;
        end
      end
      ST_MUL: cmd.mul_load = 1'b1;
      ST_DIV: cmd.div_step = 1'b1;
      ST_FIN: begin
        cmd.load_res = 1'b1;
        cmd.res_sel  = RES_INTERP;
      end
      ST_OUT: ;
      default: ;
    endcase
  end

endmodule

// ----- design/bpenv_dp.sv -----
// ---------------------------------------------------------------------------
// bpenv_dp
// Datapath: breakpoint table, point count register, scan compare,
// interpolation multiply and bit-serial restoring divide.
// ---------------------------------------------------------------------------
module bpenv_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  bpenv_pkg::cmd_t                   cmd,
  input  logic                              cfg_write_en,
  input  logic [bpenv_pkg::CFG_W-1:0]       cfg_write_data,
  input  logic [3:0]                        in_point_index,
  input  logic [bpenv_pkg::X_W-1:0]         in_point_x,
  input  logic [bpenv_pkg::Y_W-1:0]         in_point_y,
  input  logic [bpenv_pkg::POS_W-1:0]       in_query_position,
  output bpenv_pkg::stat_t                  stat,
  output logic [bpenv_pkg::POS_W-1:0]       value
);
  import bpenv_pkg::*;

  logic [CFG_W-1:0]   count_r;
  logic [CNT_W-1:0]   n_act;
  logic [IDX_W-1:0]   cnt_r;
  logic [POS_W-1:0]   pos_r;
  logic [X_W-1:0]     x0_r;
  logic [Y_W-1:0]     y0_r;
  logic [X_W-1:0]     dx_r;
  logic [Y_W-1:0]     dy_r;
  logic [POS_W-1:0]   d_r;
  logic               neg_r;
  logic [Y_W-1:0]     rem_r;
  logic [POS_W-1:0]   qd_r;
  logic [DCNT_W-1:0]  dcnt_r;
  logic [POS_W-1:0]   value_r;

  logic               ram_we;
  logic [IDX_W-1:0]   raddr;
  logic [ENTRY_W-1:0] rdata;
  logic [X_W-1:0]     rd_x;
  logic [Y_W-1:0]     rd_y;
  logic [PROD_W-1:0]  prod;
  logic [Y_W:0]       trial;
  logic               trial_ge;
  logic [POS_W-1:0]   base;
  logic [POS_W-1:0]   interp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cfg_write_en) begin
      count_r <= cfg_write_data;
    end
  end

  always_comb begin
    if (int'(count_r) > MAX_POINTS) n_act = CNT_W'(MAX_POINTS);
    else                           n_act = CNT_W'(count_r);
  end

  // slots beyond the table are dropped
  assign ram_we = cmd.wr_entry && (int'(in_point_index) < MAX_POINTS);
  assign raddr  = cmd.scan_step ? IDX_W'(cnt_r + 1'b1) : '0;

  bpenv_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_POINTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (IDX_W'(in_point_index)),
    .wdata ({in_point_x, in_point_y}),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rd_x = rdata[ENTRY_W-1:Y_W];
  assign rd_y = rdata[Y_W-1:0];

  assign stat.passed   = ({rd_x, FRAC_W'(0)} <= pos_r);
  assign stat.last     = (CNT_W'(cnt_r) + CNT_W'(1) == n_act);
  assign stat.first    = (cnt_r == '0);
  assign stat.n_zero   = (n_act == '0);
  assign stat.n_gt1    = (n_act > CNT_W'(1));
  assign stat.div_last = (dcnt_r == DCNT_W'(DIV_STEPS - 1));

  assign prod     = dy_r * d_r;
  assign trial    = {rem_r, qd_r[POS_W-1]};
  assign trial_ge = (trial >= {1'b0, dx_r});

  assign base = {y0_r, FRAC_W'(0)};
  always_comb begin
    if (neg_r) begin
      interp = (qd_r > base) ? '0 : base - qd_r;
    end else begin
      interp = base + qd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      dcnt_r <= '0;
    end else begin
      if (cmd.start_query) cnt_r <= '0;
      else if (cmd.scan_step) cnt_r <= IDX_W'(cnt_r + 1'b1);
      if (cmd.mul_load) dcnt_r <= '0;
      else if (cmd.div_step) dcnt_r <= DCNT_W'(dcnt_r + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_query) pos_r <= in_query_position;
    if (cmd.scan_step) begin
      x0_r <= rd_x;
      y0_r <= rd_y;
    end
    if (cmd.take_diff) begin
      dx_r  <= rd_x - x0_r;
      neg_r <= (rd_y < y0_r);
      dy_r  <= (rd_y < y0_r) ? y0_r - rd_y : rd_y - y0_r;
      d_r   <= pos_r - {x0_r, FRAC_W'(0)};
    end
    // quotient fits POS_W bits, so the top part of the product starts as remainder
    if (cmd.mul_load) begin
      rem_r <= prod[PROD_W-1:POS_W];
      qd_r  <= prod[POS_W-1:0];
    end else if (cmd.div_step) begin
      rem_r <= trial_ge ? Y_W'(trial - {1'b0, dx_r}) : trial[Y_W-1:0];
      qd_r  <= {qd_r[POS_W-2:0], trial_ge};
    end
    if (cmd.load_res) begin
      case (cmd.res_sel)
        RES_ZERO:   value_r <= '0;
        RES_DATA_Y: value_r <= {rd_y, FRAC_W'(0)};
        RES_INTERP: value_r <= interp;
        default:    value_r <= '0;
      endcase
    end
  end

  assign value = value_r;

endmodule

// ----- design/breakpoint_envelope_lookup_unit.sv -----
// ---------------------------------------------------------------------------
// breakpoint_envelope_lookup_unit
// Breakpoint table with piecewise linear lookup in 16.8 fixed point.
// ---------------------------------------------------------------------------
// usage:
//   a command transfers at a clock edge with start high and busy low.
//   in_operation low writes (in_point_x, in_point_y) into slot in_point_index;
//   busy stays low during the write and no result follows.
//   in_operation high evaluates the envelope at in_query_position; busy is
//   high until the result, which appears on out_envelope_value with out_valid
//   high for exactly one cycle. the receiver cannot stall, so it must take it.
//   cfg_write_en / cfg_write_data set the number of breakpoints in use; write
//   it only while busy is low.
// sequence: the scan reads one table entry per cycle from the breakpoint ram,
//   examining 1 to 16 entries. a clamp result strobes the cycle after the
//   scan; an interpolation adds the multiply state, the bit-serial divide
//   and a final add before the strobe. with no points in use the strobe
//   comes in the next cycle. busy drops after the strobe, and writes can
//   follow every cycle.
// reset: synchronous, active low; clears the point count and the sequencer.
//   the table itself is not cleared, so slots must be written before use.
// ---------------------------------------------------------------------------
module breakpoint_envelope_lookup_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_operation,
  input  logic [3:0]                  in_point_index,
  input  logic [bpenv_pkg::X_W-1:0]   in_point_x,
  input  logic [bpenv_pkg::Y_W-1:0]   in_point_y,
  input  logic [bpenv_pkg::POS_W-1:0] in_query_position,
  input  logic                        cfg_write_en,
  input  logic [bpenv_pkg::CFG_W-1:0] cfg_write_data,
  output logic                        out_valid,
  output logic [bpenv_pkg::POS_W-1:0] out_envelope_value
);
  import bpenv_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  bpenv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .op        (in_operation),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  bpenv_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .cfg_write_en      (cfg_write_en),
    .cfg_write_data    (cfg_write_data),
    .in_point_index    (in_point_index),
    .in_point_x        (in_point_x),
    .in_point_y        (in_point_y),
    .in_query_position (in_query_position),
    .stat              (stat),
    .value             (out_envelope_value)
  );

endmodule
